[src/mlm_pkg.sv]
// Package: shared types and codes for the mutex lock manager.
`timescale 1ns / 1ps
package mlm_pkg;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_ACQUIRE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_DELETE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CREATED  = 4'd0,
        ST_ACQUIRED = 4'd1,
        ST_BLOCKED  = 4'd2,
        ST_FREED    = 4'd3,
        ST_HANDED   = 4'd4,
        ST_DELETED  = 4'd5,
        ST_NOLOCK   = 4'd6,
        ST_OWNER    = 4'd7,
        ST_NOTOWNER = 4'd8,
        ST_FULL     = 4'd9,
        ST_QFULL    = 4'd10
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  lock_index;
        logic [15:0] requester_pid;
    } t_req;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  result_lock;
        logic [15:0] new_owner_pid;
        logic        owner_valid;
    } t_rsp;

    // Back-end state machine.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HAND
    } t_state;

endpackage

[src/mlm_fifo.sv]
// Small synchronous queue used as the request queue in front of the back end and at the output.
`timescale 1ns / 1ps
module mlm_fifo #(
    parameter int W = 22,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_rd, r_wr;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

[src/mlm_back.sv]
// Back end: lock table, waiter memory and command execution.
`timescale 1ns / 1ps
module mlm_back #(
    parameter int NUM_LOCKS = 16,
    parameter int WAITERS_PER_LOCK = 8,
    parameter int PID_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  mlm_pkg::t_req i_req,
    output logic          o_req_pop,
    output logic          o_rsp_push,
    output mlm_pkg::t_rsp o_rsp,
    input  logic          i_rsp_full
);
    import mlm_pkg::*;

    localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int QW = (WAITERS_PER_LOCK > 1) ? $clog2(WAITERS_PER_LOCK) : 1;
    localparam int CW = $clog2(WAITERS_PER_LOCK + 1);
    localparam int MD = NUM_LOCKS * WAITERS_PER_LOCK;
    localparam int MW = $clog2(MD);

    logic [NUM_LOCKS-1:0] r_in_use, r_held;
    logic [PID_BITS-1:0]  r_owner [NUM_LOCKS];
    logic [QW-1:0]        r_head  [NUM_LOCKS];
    logic [CW-1:0]        r_count [NUM_LOCKS];
    logic [PID_BITS-1:0]  r_wmem  [MD];
    logic [PID_BITS-1:0]  r_wrd;

    t_state r_state, n_state;
    t_req   r_req;
    logic [LW-1:0] r_slot;

    // Lowest free slot.
    logic [LW-1:0] w_free;
    logic          w_free_ok;
    always_comb begin
        w_free = '0;
        w_free_ok = 1'b0;
        for (int k = NUM_LOCKS - 1; k >= 0; k--) begin
            if (!r_in_use[k]) begin
                w_free = LW'(k);
                w_free_ok = 1'b1;
            end
        end
    end

    logic          w_idx_ok;
    logic [LW-1:0] w_idx;
    logic [PID_BITS-1:0] w_pid;
    logic [QW:0]   w_pos;
    logic [QW-1:0] w_posm;
    logic [QW-1:0] w_hnext;

    assign w_idx_ok = ({28'd0, r_req.lock_index} < 32'(NUM_LOCKS));
    assign w_idx = LW'(r_req.lock_index);
    assign w_pid = PID_BITS'(r_req.requester_pid);
    always_comb begin
        w_pos = (QW+1)'(r_head[w_idx]) + (QW+1)'(r_count[w_idx]);
        if (w_pos >= (QW+1)'(WAITERS_PER_LOCK)) begin
            w_pos = w_pos - (QW+1)'(WAITERS_PER_LOCK);
        end
        w_posm = w_pos[QW-1:0];
        w_hnext = (r_head[w_idx] == QW'(WAITERS_PER_LOCK-1)) ? '0
                  : QW'(r_head[w_idx] + 1'b1);
    end

    logic [MW-1:0] w_waddr, w_raddr;
    assign w_waddr = MW'(w_idx * WAITERS_PER_LOCK) + MW'(w_posm);
    assign w_raddr = MW'(LW'(i_req.lock_index) * WAITERS_PER_LOCK)
                   + MW'(r_head[LW'(i_req.lock_index)]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req_valid) n_state = S_EXEC;
            S_EXEC: if (!i_rsp_full) n_state = S_HAND;
            S_HAND: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_req_pop  = (r_state == S_IDLE) && i_req_valid;
    assign o_rsp_push = (r_state == S_HAND);

    // Decision made in S_EXEC; response built in S_HAND from updated table.
    logic [3:0] w_status;
    logic [LW-1:0] w_slot;
    logic w_ok;
    always_comb begin
        w_status = ST_NOLOCK;
        w_slot = w_idx;
        w_ok = 1'b1;
        if (r_req.command == CMD_CREATE) begin
            w_status = w_free_ok ? ST_CREATED : ST_FULL;
            w_slot = w_free;
        end else if (!w_idx_ok || !r_in_use[w_idx]) begin
            w_status = ST_NOLOCK;
            w_ok = 1'b0;
        end else begin
            unique case (t_cmd'(r_req.command))
                CMD_ACQUIRE: begin
                    if (!r_held[w_idx]) w_status = ST_ACQUIRED;
                    else if (r_owner[w_idx] == w_pid) w_status = ST_OWNER;
                    else if (r_count[w_idx] >= CW'(WAITERS_PER_LOCK)) w_status = ST_QFULL;
                    else w_status = ST_BLOCKED;
                end
                CMD_RELEASE: begin
                    if (!r_held[w_idx] || r_owner[w_idx] != w_pid) w_status = ST_NOTOWNER;
                    else if (r_count[w_idx] == '0) w_status = ST_FREED;
                    else w_status = ST_HANDED;
                end
                CMD_DELETE: w_status = ST_DELETED;
                default: w_status = ST_NOLOCK;
            endcase
        end
    end

    logic [3:0] r_status;
    logic r_ok, r_full;

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_req <= i_req;
            r_wrd <= r_wmem[w_raddr];
        end
        if (r_state == S_EXEC && !i_rsp_full) begin
            r_status <= w_status;
            r_slot <= w_slot;
            r_ok <= w_ok;
            r_full <= (w_status == ST_FULL);
            if (w_status == ST_BLOCKED) r_wmem[w_waddr] <= w_pid;
            if (w_status == ST_ACQUIRED) r_owner[w_idx] <= w_pid;
            if (w_status == ST_HANDED) r_owner[w_idx] <= r_wrd;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_in_use <= '0;
            r_held <= '0;
            for (int k = 0; k < NUM_LOCKS; k++) begin
                r_head[k] <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC && !i_rsp_full) begin
                unique case (w_status)
                    ST_CREATED, ST_DELETED: begin
                        r_in_use[w_slot] <= (w_status == ST_CREATED);
                        r_held[w_slot] <= 1'b0;
                        r_head[w_slot] <= '0;
                        r_count[w_slot] <= '0;
                    end
                    ST_ACQUIRED: r_held[w_idx] <= 1'b1;
                    ST_BLOCKED: r_count[w_idx] <= r_count[w_idx] + 1'b1;
                    ST_FREED: r_held[w_idx] <= 1'b0;
                    ST_HANDED: begin
                        r_head[w_idx] <= w_hnext;
                        r_count[w_idx] <= r_count[w_idx] - 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    logic w_hv;
    assign w_hv = r_ok && !r_full && r_held[r_slot];
    always_comb begin
        o_rsp.status = r_status;
        o_rsp.result_lock = r_full ? 4'd0 : 4'(r_slot);
        o_rsp.new_owner_pid = w_hv ? 16'(r_owner[r_slot]) : 16'd0;
        o_rsp.owner_valid = w_hv;
    end
endmodule

[src/mutex_lock_manager_top.sv]
// Top level: mutex lock manager with FIFO waiters.
// Requests enter a two-entry queue (front end) and are executed one at a time by
// the back end, a three-state sequencer: fetch the request plus the head waiter
// from the waiter memory, update the lock table, then post the result. The back
// end takes a new request only after posting the last result, and it waits
// before the table update while the output queue is full. Results wait in a
// two-entry output queue, so the back end can post results before they are popped.
// Create takes the lowest free slot; its index is the lock id.
`timescale 1ns / 1ps
module mutex_lock_manager_top #(
    parameter int NUM_LOCKS = 16,
    parameter int WAITERS_PER_LOCK = 8,
    parameter int PID_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  mlm_pkg::t_req i_req,
    output logic          empty,
    input  logic          pop,
    output mlm_pkg::t_rsp o_rsp
);
    import mlm_pkg::*;

    t_req w_req;
    t_rsp w_rsp;
    logic w_req_empty, w_req_pop, w_rsp_push, w_rsp_full;

    // Front end: request queue.
    mlm_fifo #(.W($bits(t_req)), .DEPTH(2)) u_req_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(i_req), .o_full(full),
        .i_pop(w_req_pop), .o_data(w_req), .o_empty(w_req_empty)
    );

    mlm_back #(
        .NUM_LOCKS(NUM_LOCKS), .WAITERS_PER_LOCK(WAITERS_PER_LOCK), .PID_BITS(PID_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(!w_req_empty), .i_req(w_req), .o_req_pop(w_req_pop),
        .o_rsp_push(w_rsp_push), .o_rsp(w_rsp), .i_rsp_full(w_rsp_full)
    );

    // Result queue; one slot is always free when the back end posts a transaction.
    mlm_fifo #(.W($bits(t_rsp)), .DEPTH(2)) u_rsp_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_rsp_push), .i_data(w_rsp), .o_full(w_rsp_full),
        .i_pop(pop), .o_data(o_rsp), .o_empty(empty)
    );
endmodule
